// ===== rtl/ffha_pkg.sv =====
`default_nettype none

package ffha_pkg;

  // store word and tag layout
  localparam int WORD_W         = 17;
  localparam int HEAP_BYTES_DEF = 65536;
  localparam int LIMIT_W        = 17;
  localparam int LIMIT_RESET    = 65536;
  localparam int BREAK_RESET    = 16;
  localparam int TAG_BYTES      = 8;
  localparam int MIN_REMAINDER  = 16;

  // operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [15:0] request_size;
    logic [15:0] block_address;
  } ffha_in_t;

  typedef struct packed {
    logic [15:0] payload_address;
    logic        ok;
  } ffha_out_t;

endpackage

`default_nettype wire

// ===== rtl/ffha_in_if.sv =====
`default_nettype none

interface ffha_in_if;
  logic               valid;
  logic               ready;
  ffha_pkg::ffha_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/ffha_out_if.sv =====
`default_nettype none

interface ffha_out_if;
  logic                valid;
  logic                ready;
  ffha_pkg::ffha_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/ffha_ram.sv =====
`default_nettype none

module ffha_ram #(
  parameter int WIDTH = ffha_pkg::WORD_W,
  parameter int DEPTH = ffha_pkg::HEAP_BYTES_DEF / 4
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ===== rtl/first_fit_heap_allocator.sv =====
`default_nettype none

// First-fit heap allocator with boundary tags over a single-port word store
// (HEAP_BYTES/4 words of 17 bits, registered read). Each block carries a
// header and a footer word holding size | allocated. An allocate word rounds
// request_size + 8 up to a multiple of 8, walks the blocks from the prologue
// and places into the first free block that fits, splitting off the rest when
// 16 bytes or more remain; if nothing fits the break grows by the rounded
// size (bounded by min(heap_limit_bytes, HEAP_BYTES)), the new block merges
// with a free last block and is then placed. A free word clears the
// allocated bit and merges with free neighbors. One word is worked on at a
// time: in_ch.ready is high only while the sequencer is idle. Most steps are
// one access of the store port: a free reads and rewrites the header, writes
// the footer and merges; an allocate reads the header of each block visited
// and then places, extends and merges as needed; the result word is handed
// over once the output register is free. After reset the sequencer writes the
// prologue and epilogue tags before it accepts a word. The limit register may
// be written at any time the block is idle.
module first_fit_heap_allocator #(
  parameter int HEAP_BYTES = ffha_pkg::HEAP_BYTES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  ffha_in_if.sink                             in_ch,
  ffha_out_if.source                          out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [ffha_pkg::LIMIT_W-1:0]   cfg_wdata
);

  localparam int WORDS = HEAP_BYTES / 4;
  localparam int IDX_W = $clog2(WORDS);
  // byte offsets: wide enough for the walk (break + size) and the word index
  localparam int OFF_W = (IDX_W + 2 > 18) ? IDX_W + 2 : 18;
  localparam int W     = ffha_pkg::WORD_W;
  localparam int CAP   = (HEAP_BYTES > 131071) ? 131071 : HEAP_BYTES;
  localparam logic [17:0] LIM_CAP = 18'(CAP);

  localparam logic [OFF_W-1:0] K4  = OFF_W'(4);
  localparam logic [OFF_W-1:0] K8  = OFF_W'(ffha_pkg::TAG_BYTES);
  localparam logic [OFF_W-1:0] K12 = OFF_W'(12);

  // sequencer states
  localparam logic [5:0] ST_INIT1 = 6'd0;
  localparam logic [5:0] ST_INIT2 = 6'd1;
  localparam logic [5:0] ST_INIT3 = 6'd2;
  localparam logic [5:0] ST_IDLE  = 6'd3;
  localparam logic [5:0] ST_F_RH  = 6'd4;
  localparam logic [5:0] ST_F_WH  = 6'd5;
  localparam logic [5:0] ST_F_WF  = 6'd6;
  localparam logic [5:0] ST_M0    = 6'd7;
  localparam logic [5:0] ST_M1    = 6'd8;
  localparam logic [5:0] ST_M2    = 6'd9;
  localparam logic [5:0] ST_M3    = 6'd10;
  localparam logic [5:0] ST_M4    = 6'd11;
  localparam logic [5:0] ST_M_PA1 = 6'd12;
  localparam logic [5:0] ST_M_NA1 = 6'd13;
  localparam logic [5:0] ST_M_NA2 = 6'd14;
  localparam logic [5:0] ST_M_B1  = 6'd15;
  localparam logic [5:0] ST_M_B2  = 6'd16;
  localparam logic [5:0] ST_M_B3  = 6'd17;
  localparam logic [5:0] ST_M_B4  = 6'd18;
  localparam logic [5:0] ST_M_PV0 = 6'd19;
  localparam logic [5:0] ST_M_PV1 = 6'd20;
  localparam logic [5:0] ST_A_LP  = 6'd21;
  localparam logic [5:0] ST_A_CHK = 6'd22;
  localparam logic [5:0] ST_EXT   = 6'd23;
  localparam logic [5:0] ST_E1    = 6'd24;
  localparam logic [5:0] ST_E2    = 6'd25;
  localparam logic [5:0] ST_P0    = 6'd26;
  localparam logic [5:0] ST_P1    = 6'd27;
  localparam logic [5:0] ST_P_S1  = 6'd28;
  localparam logic [5:0] ST_P_S2  = 6'd29;
  localparam logic [5:0] ST_P_S3  = 6'd30;
  localparam logic [5:0] ST_P_N1  = 6'd31;
  localparam logic [5:0] ST_DONE  = 6'd32;

  // sequencer and datapath registers
  logic [5:0]         state_r, state_nxt;
  logic [OFF_W-1:0]   p_r, p_nxt;        // current payload offset
  logic [OFF_W-1:0]   q_r, q_nxt;        // previous block payload
  logic [OFF_W-1:0]   n_r, n_nxt;        // next block payload
  logic [18:0]        s_r, s_nxt;        // merged size, masked on write
  logic [W-1:0]       psz_r, psz_nxt;
  logic               pa_r, pa_nxt;
  logic [W-1:0]       need_r, need_nxt;
  logic [W-1:0]       orig_r, orig_nxt;
  logic [W-1:0]       brk_r, brk_nxt;
  logic [W-1:0]       limit_r;
  logic               ret_alloc_r, ret_alloc_nxt;
  logic [15:0]        res_addr_r, res_addr_nxt;
  logic               res_ok_r, res_ok_nxt;
  logic               out_valid_r, out_valid_nxt;
  ffha_pkg::ffha_out_t out_data_r, out_data_nxt;

  // store port
  logic               ram_we;
  logic [OFF_W-1:0]   ram_off;
  logic [W-1:0]       ram_wdata;
  logic [W-1:0]       ram_rdata;

  // decoded read word
  logic [W-1:0]       rt;
  logic [OFF_W-1:0]   rt_o;
  logic [18:0]        s_sum;
  logic [17:0]        brk_sum;
  logic [17:0]        lim;
  logic [W-1:0]       need_rq;
  logic [W-1:0]       s_tag;

  assign rt      = {ram_rdata[W-1:1], 1'b0};
  assign rt_o    = OFF_W'(rt);
  assign brk_sum = {1'b0, brk_r} + {1'b0, need_r};
  assign lim     = ({1'b0, limit_r} < LIM_CAP) ? {1'b0, limit_r} : LIM_CAP;
  // size + 8 rounded up to a multiple of 8
  assign need_rq = ({1'b0, in_ch.data.request_size} + W'(15)) & ~W'(7);
  assign s_tag   = {s_r[W-1:1], 1'b0};

  ffha_ram #(
    .WIDTH(W),
    .DEPTH(WORDS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_off[IDX_W+1:2]),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    p_nxt         = p_r;
    q_nxt         = q_r;
    n_nxt         = n_r;
    s_nxt         = s_r;
    psz_nxt       = psz_r;
    pa_nxt        = pa_r;
    need_nxt      = need_r;
    orig_nxt      = orig_r;
    brk_nxt       = brk_r;
    ret_alloc_nxt = ret_alloc_r;
    res_addr_nxt  = res_addr_r;
    res_ok_nxt    = res_ok_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_off       = '0;
    ram_wdata     = '0;
    s_sum         = '0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      // prologue header/footer and epilogue header
      ST_INIT1: begin
        ram_we    = 1'b1;
        ram_off   = K4;
        ram_wdata = W'(9);
        state_nxt = ST_INIT2;
      end
      ST_INIT2: begin
        ram_we    = 1'b1;
        ram_off   = K8;
        ram_wdata = W'(9);
        state_nxt = ST_INIT3;
      end
      ST_INIT3: begin
        ram_we    = 1'b1;
        ram_off   = K12;
        ram_wdata = W'(1);
        state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_ch.valid) begin
          res_addr_nxt = '0;
          res_ok_nxt   = 1'b1;
          need_nxt     = need_rq;
          if (in_ch.data.operation == ffha_pkg::OP_FREE) begin
            p_nxt     = OFF_W'(in_ch.data.block_address);
            state_nxt = ST_F_RH;
          end else begin
            p_nxt     = K8;
            state_nxt = ST_A_LP;
          end
        end
      end
      // free: clear allocated bit in header and footer
      ST_F_RH: begin
        ram_off   = p_r - K4;
        state_nxt = ST_F_WH;
      end
      ST_F_WH: begin
        s_nxt     = 19'(rt);
        ram_we    = 1'b1;
        ram_off   = p_r - K4;
        ram_wdata = rt;
        state_nxt = ST_F_WF;
      end
      ST_F_WF: begin
        ram_we        = 1'b1;
        ram_off       = p_r + OFF_W'(s_r[W-1:0]) - K8;
        ram_wdata     = s_r[W-1:0];
        ret_alloc_nxt = 1'b0;
        state_nxt     = ST_M0;
      end
      // coalesce: gather both neighbor tags first
      ST_M0: begin
        ram_off   = p_r - K8;
        state_nxt = ST_M1;
      end
      ST_M1: begin
        q_nxt     = p_r - rt_o;
        ram_off   = p_r - rt_o - K4;
        state_nxt = ST_M2;
      end
      ST_M2: begin
        pa_nxt    = ram_rdata[0];
        psz_nxt   = rt;
        ram_off   = p_r - K4;
        state_nxt = ST_M3;
      end
      ST_M3: begin
        s_nxt     = 19'(rt);
        n_nxt     = p_r + rt_o;
        ram_off   = p_r + rt_o - K4;
        state_nxt = ST_M4;
      end
      ST_M4: begin
        priority if (pa_r && ram_rdata[0]) begin
          state_nxt = ret_alloc_r ? ST_P0 : ST_DONE;
        end else if (pa_r) begin
          // next block free
          s_sum     = s_r + 19'(rt);
          s_nxt     = s_sum;
          ram_we    = 1'b1;
          ram_off   = p_r - K4;
          ram_wdata = s_sum[W-1:0];
          state_nxt = ST_M_PA1;
        end else if (ram_rdata[0]) begin
          // previous block free
          s_sum     = s_r + 19'(psz_r);
          s_nxt     = s_sum;
          ram_we    = 1'b1;
          ram_off   = q_r - K4;
          ram_wdata = s_sum[W-1:0];
          state_nxt = ST_M_NA1;
        end else begin
          // both free: fetch footer of next block
          s_nxt     = s_r + 19'(psz_r);
          ram_off   = n_r + rt_o - K8;
          state_nxt = ST_M_B1;
        end
      end
      ST_M_PA1: begin
        ram_we    = 1'b1;
        ram_off   = p_r + OFF_W'(s_tag) - K8;
        ram_wdata = s_r[W-1:0];
        state_nxt = ret_alloc_r ? ST_P0 : ST_DONE;
      end
      ST_M_NA1: begin
        ram_off   = p_r - K4;
        state_nxt = ST_M_NA2;
      end
      ST_M_NA2: begin
        ram_we    = 1'b1;
        ram_off   = p_r + rt_o - K8;
        ram_wdata = s_r[W-1:0];
        state_nxt = ST_M_PV0;
      end
      ST_M_B1: begin
        s_sum     = s_r + 19'(rt);
        s_nxt     = s_sum;
        ram_we    = 1'b1;
        ram_off   = q_r - K4;
        ram_wdata = s_sum[W-1:0];
        state_nxt = ST_M_B2;
      end
      ST_M_B2: begin
        ram_off   = p_r - K4;
        state_nxt = ST_M_B3;
      end
      ST_M_B3: begin
        n_nxt     = p_r + rt_o;
        ram_off   = p_r + rt_o - K4;
        state_nxt = ST_M_B4;
      end
      ST_M_B4: begin
        ram_we    = 1'b1;
        ram_off   = n_r + rt_o - K8;
        ram_wdata = s_r[W-1:0];
        state_nxt = ST_M_PV0;
      end
      // merged block starts at the previous payload
      ST_M_PV0: begin
        ram_off   = p_r - K8;
        state_nxt = ST_M_PV1;
      end
      ST_M_PV1: begin
        p_nxt     = p_r - rt_o;
        state_nxt = ret_alloc_r ? ST_P0 : ST_DONE;
      end
      // first-fit walk: read a block header, then check it
      ST_A_LP: begin
        ram_off = p_r - K4;
        if (p_r > OFF_W'(brk_r)) begin
          state_nxt = ST_EXT;
        end else begin
          state_nxt = ST_A_CHK;
        end
      end
      ST_A_CHK: begin
        priority if (rt == '0) begin
          state_nxt = ST_EXT;
        end else if ((need_r <= rt) && !ram_rdata[0]) begin
          state_nxt = ST_P0;
        end else begin
          p_nxt     = p_r + rt_o;
          state_nxt = ST_A_LP;
        end
      end
      // grow the break
      ST_EXT: begin
        if (brk_sum > lim) begin
          res_ok_nxt   = 1'b0;
          res_addr_nxt = '0;
          state_nxt    = ST_DONE;
        end else begin
          p_nxt     = OFF_W'(brk_r);
          brk_nxt   = brk_sum[W-1:0];
          ram_we    = 1'b1;
          ram_off   = OFF_W'(brk_r) - K4;
          ram_wdata = need_r;
          state_nxt = ST_E1;
        end
      end
      ST_E1: begin
        ram_we    = 1'b1;
        ram_off   = p_r + OFF_W'(need_r) - K8;
        ram_wdata = need_r;
        state_nxt = ST_E2;
      end
      ST_E2: begin
        // new epilogue header
        ram_we        = 1'b1;
        ram_off       = p_r + OFF_W'(need_r) - K4;
        ram_wdata     = W'(1);
        ret_alloc_nxt = 1'b1;
        state_nxt     = ST_M0;
      end
      // placement, split when enough remains
      ST_P0: begin
        ram_off   = p_r - K4;
        state_nxt = ST_P1;
      end
      ST_P1: begin
        orig_nxt = rt;
        ram_we   = 1'b1;
        ram_off  = p_r - K4;
        if ((rt >= need_r) && ((rt - need_r) >= W'(ffha_pkg::MIN_REMAINDER))) begin
          ram_wdata = {need_r[W-1:1], 1'b1};
          state_nxt = ST_P_S1;
        end else begin
          ram_wdata = {rt[W-1:1], 1'b1};
          state_nxt = ST_P_N1;
        end
      end
      ST_P_S1: begin
        ram_we    = 1'b1;
        ram_off   = p_r + OFF_W'(need_r) - K8;
        ram_wdata = {need_r[W-1:1], 1'b1};
        state_nxt = ST_P_S2;
      end
      ST_P_S2: begin
        ram_we    = 1'b1;
        ram_off   = p_r + OFF_W'(need_r) - K4;
        ram_wdata = orig_r - need_r;
        state_nxt = ST_P_S3;
      end
      ST_P_S3: begin
        ram_we       = 1'b1;
        ram_off      = p_r + OFF_W'(orig_r) - K8;
        ram_wdata    = orig_r - need_r;
        res_addr_nxt = p_r[15:0];
        res_ok_nxt   = 1'b1;
        state_nxt    = ST_DONE;
      end
      ST_P_N1: begin
        ram_we       = 1'b1;
        ram_off      = p_r + OFF_W'(orig_r) - K8;
        ram_wdata    = {orig_r[W-1:1], 1'b1};
        res_addr_nxt = p_r[15:0];
        res_ok_nxt   = 1'b1;
        state_nxt    = ST_DONE;
      end
      // hand the result to the output register when it is free
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.payload_address = res_addr_r;
          out_data_nxt.ok              = res_ok_r;
          state_nxt                    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT1;
      brk_r       <= W'(ffha_pkg::BREAK_RESET);
      limit_r     <= W'(ffha_pkg::LIMIT_RESET);
      out_valid_r <= 1'b0;
      ret_alloc_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      brk_r       <= brk_nxt;
      out_valid_r <= out_valid_nxt;
      ret_alloc_r <= ret_alloc_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    p_r        <= p_nxt;
    q_r        <= q_nxt;
    n_r        <= n_nxt;
    s_r        <= s_nxt;
    psz_r      <= psz_nxt;
    pa_r       <= pa_nxt;
    need_r     <= need_nxt;
    orig_r     <= orig_nxt;
    res_addr_r <= res_addr_nxt;
    res_ok_r   <= res_ok_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/ffha_checker.sv =====
`default_nettype none

module ffha_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] out_payload_address,
  input wire logic        out_ok
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload_address) && $stable(out_ok))
    else $error("result word changed while stalled");

  // one word at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after accept");

  // failed allocation reports a null offset
  a_fail_null: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_payload_address == 16'd0)
    else $error("failed allocation with nonzero offset");

  // tag setup after reset keeps input closed
  a_init_busy: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("ready during tag setup");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_payload_address(out_ch.data.payload_address),
  .out_ok             (out_ch.data.ok)
);

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import ffha_pkg::*;

  localparam int STORE_WORDS  = HEAP_BYTES_DEF / 4;
  localparam int STALL_LIMIT  = 60000;  // worst walk over ~8192 blocks plus the long hold-off
  localparam int RANDOM_ITEMS = 1550;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [LIMIT_W-1:0] cfg_wdata;

  ffha_in_if  in_bus ();
  ffha_out_if out_bus ();

  first_fit_heap_allocator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus.sink),
    .out_ch    (out_bus.source),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // heap mirror: word store, break and limit kept alongside the block
  // ---------------------------------------------------------------------------
  logic [WORD_W-1:0] heap_mem [STORE_WORDS];
  int unsigned       heap_brk;
  int unsigned       heap_limit;

  ffha_out_t   pending_results [$];  // results still owed by the block, oldest first
  int unsigned live_payloads [$];    // payload offsets currently allocated

  int err_count;
  int n_alloc, n_free, n_alloc_fail, n_results, n_limits;
  int unsigned top_brk;

  logic no_idle;  // set during the stretch where neither side idles

  // word access: offset/4 modulo the store, low bits dropped
  function automatic int unsigned heap_rd(int unsigned a);
    return heap_mem[(a >> 2) % STORE_WORDS];
  endfunction

  function automatic void heap_wr(int unsigned a, int unsigned v);
    heap_mem[(a >> 2) % STORE_WORDS] = v[WORD_W-1:0];
  endfunction

  function automatic int unsigned tag_sz(int unsigned a);
    return heap_rd(a) & 32'h1FFFE;
  endfunction

  function automatic int unsigned tag_alloc(int unsigned a);
    return heap_rd(a) & 32'h1;
  endfunction

  function automatic int unsigned blk_next(int unsigned p);
    return p + tag_sz(p - 4);
  endfunction

  function automatic int unsigned blk_prev(int unsigned p);
    return p - tag_sz(p - 8);
  endfunction

  function automatic int unsigned blk_ftr(int unsigned p);
    return p + tag_sz(p - 4) - 8;
  endfunction

  // boundary-tag merge of a free block with its free neighbors
  function automatic int unsigned coalesce(int unsigned p);
    int unsigned pa, na, s;
    pa = tag_alloc(blk_prev(p) - 4);
    na = tag_alloc(blk_next(p) - 4);
    s  = tag_sz(p - 4);
    if (pa != 0 && na != 0) begin
      return p;
    end
    if (pa != 0) begin
      // next is free
      s += tag_sz(blk_next(p) - 4);
      heap_wr(p - 4, s);
      heap_wr(blk_ftr(p), s);
    end else if (na != 0) begin
      // prev is free
      s += tag_sz(blk_prev(p) - 4);
      heap_wr(blk_prev(p) - 4, s);
      heap_wr(blk_ftr(p), s);
      p = blk_prev(p);
    end else begin
      // both neighbors free
      s += tag_sz(blk_prev(p) - 4) + tag_sz(blk_ftr(blk_next(p)));
      heap_wr(blk_prev(p) - 4, s);
      heap_wr(blk_ftr(blk_next(p)), s);
      p = blk_prev(p);
    end
    return p;
  endfunction

  // mark a block allocated, splitting off the tail when 16 bytes or more remain
  function automatic void place_block(int unsigned p, int unsigned need);
    int unsigned orig;
    orig = tag_sz(p - 4);
    if (orig >= need && orig - need >= MIN_REMAINDER) begin
      heap_wr(p - 4, need | 1);
      heap_wr(blk_ftr(p), need | 1);
      p = blk_next(p);
      heap_wr(p - 4, orig - need);
      heap_wr(blk_ftr(p), orig - need);
    end else begin
      heap_wr(p - 4, orig | 1);
      heap_wr(blk_ftr(p), orig | 1);
    end
  endfunction

  function automatic void heap_reset();
    foreach (heap_mem[i]) heap_mem[i] = '0;
    heap_mem[1] = WORD_W'(TAG_BYTES | 1);
    heap_mem[2] = WORD_W'(TAG_BYTES | 1);
    heap_mem[3] = WORD_W'(1);
    heap_brk   = BREAK_RESET;
    heap_limit = LIMIT_RESET;
  endfunction

  // works out the result of one word and updates the mirror
  function automatic ffha_out_t heap_op(ffha_in_t w);
    ffha_out_t   r;
    int unsigned need, lim, p, s;
    r.payload_address = '0;
    r.ok              = 1'b1;
    if (w.operation == OP_FREE) begin
      p = 32'(w.block_address);
      s = tag_sz(p - 4);
      heap_wr(p - 4, s);
      heap_wr(blk_ftr(p), s);
      void'(coalesce(p));
      n_free++;
      return r;
    end
    n_alloc++;
    need = (int'(w.request_size) + TAG_BYTES + 7) & ~32'h7;
    lim  = (heap_limit < HEAP_BYTES_DEF) ? heap_limit : HEAP_BYTES_DEF;
    // first-fit walk from the prologue
    p = 8;
    while (p <= heap_brk) begin
      s = tag_sz(p - 4);
      if (s == 0) break;
      if (need <= s && tag_alloc(p - 4) == 0) begin
        place_block(p, need);
        r.payload_address = p[15:0];
        live_payloads.push_back(p);
        return r;
      end
      p += s;
    end
    // extend the break
    if (heap_brk + need > lim) begin
      r.ok = 1'b0;
      n_alloc_fail++;
      return r;
    end
    p        = heap_brk;
    heap_brk = (heap_brk + need) & 32'h1FFFF;
    if (heap_brk > top_brk) top_brk = heap_brk;
    heap_wr(p - 4, need);
    heap_wr(blk_ftr(p), need);
    heap_wr(blk_next(p) - 4, 1);
    p = coalesce(p);
    place_block(p, need);
    r.payload_address = p[15:0];
    live_payloads.push_back(p);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random stalls, one long hold-off, checking
  // ---------------------------------------------------------------------------
  int  hold_left;
  bit  hold_done;
  int  quiet_cycles;

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch on %s: got %0d expected %0d", $time, what, got, want);
    err_count++;
  endtask

  always @(posedge clk) begin
    ffha_out_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result word, payload_address", out_bus.data.payload_address, -1);
      end else begin
        want = pending_results.pop_front();
        if (out_bus.data.payload_address !== want.payload_address)
          report_mismatch("payload_address", out_bus.data.payload_address, want.payload_address);
        if (out_bus.data.ok !== want.ok)
          report_mismatch("ok", out_bus.data.ok, want.ok);
      end
      // long hold-off once, after a few hundred results, while the sender keeps going
      if (n_results == 300 && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 400;
      end
    end
    if (hold_left > 0) begin
      out_bus.ready <= 1'b0;
      hold_left--;
    end else if (no_idle) begin
      out_bus.ready <= 1'b1;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= 6);
    end
  end

  // watchdog: cycles without any word moving on either channel
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (rst_n) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog expired after %0d idle cycles", quiet_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus side
  // ---------------------------------------------------------------------------

  // offer one word, wait for it to be taken, then log its expected result
  task automatic send_word(logic op, logic [15:0] req, logic [15:0] addr);
    ffha_in_t w;
    if (!no_idle) begin
      while ($urandom_range(99) < 6) begin
        in_bus.valid <= 1'b0;
        @(posedge clk);
      end
    end
    w.operation     = op;
    w.request_size  = req;
    w.block_address = addr;
    in_bus.valid <= 1'b1;
    in_bus.data  <= w;
    do @(posedge clk); while (!in_bus.ready);
    pending_results.push_back(heap_op(w));
  endtask

  // stop offering and wait until every owed result has arrived
  task automatic drain();
    in_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    heap_limit = 32'(v);
    n_limits++;
  endtask

  // free a live payload picked by position in the live list
  task automatic free_at(int idx, logic [15:0] junk_req);
    int unsigned a;
    a = live_payloads[idx];
    live_payloads.delete(idx);
    send_word(OP_FREE, junk_req, a[15:0]);
  endtask

  task automatic random_word();
    int unsigned pct;
    logic [15:0] req;
    if (live_payloads.size() > 0 &&
        (live_payloads.size() > 80 || $urandom_range(99) < 45)) begin
      free_at(int'($urandom_range(live_payloads.size() - 1)), 16'($urandom));
    end else begin
      pct = $urandom_range(99);
      if (pct < 70)      req = 16'($urandom_range(64));
      else if (pct < 90) req = 16'($urandom_range(1024, 65));
      else if (pct < 97) req = 16'($urandom_range(8000, 1025));
      else               req = 16'($urandom);
      send_word(OP_ALLOC, req, 16'($urandom));
    end
  endtask

  typedef struct {
    logic        op;
    logic [15:0] req;
    int          pick;       // position in the live list for a free
    bit          typed;      // expected result written in the row
    logic [15:0] want_addr;
    logic        want_ok;
  } stim_row_t;

  // directed rows: each merge case of free, zero and largest requests,
  // a failed extension, and payloads high in the heap
  stim_row_t directed [] = '{
    '{OP_ALLOC, 16'd0,     0, 1'b1, 16'd16, 1'b1},  // zero request right after reset
    '{OP_ALLOC, 16'hFFFF,  0, 1'b1, 16'd0,  1'b0},  // largest request overruns the limit
    '{OP_ALLOC, 16'd1,     0, 1'b0, 16'd0,  1'b0},
    '{OP_ALLOC, 16'd100,   0, 1'b0, 16'd0,  1'b0},
    '{OP_ALLOC, 16'd24,    0, 1'b0, 16'd0,  1'b0},
    '{OP_FREE,  16'hFFFF,  1, 1'b1, 16'd0,  1'b1},  // both neighbors allocated
    '{OP_FREE,  16'hFFFF,  0, 1'b1, 16'd0,  1'b1},  // next neighbor free
    '{OP_FREE,  16'hFFFF,  0, 1'b1, 16'd0,  1'b1},  // prev neighbor free
    '{OP_ALLOC, 16'd200,   0, 1'b0, 16'd0,  1'b0},  // too big for the merged hole, so the break grows
    '{OP_ALLOC, 16'd8,     0, 1'b0, 16'd0,  1'b0},
    '{OP_ALLOC, 16'd8,     0, 1'b0, 16'd0,  1'b0},
    '{OP_ALLOC, 16'd8,     0, 1'b0, 16'd0,  1'b0},
    '{OP_FREE,  16'h0000,  2, 1'b1, 16'd0,  1'b1},
    '{OP_FREE,  16'h0000,  3, 1'b1, 16'd0,  1'b1},
    '{OP_FREE,  16'h0000,  2, 1'b1, 16'd0,  1'b1},  // both neighbors free
    '{OP_ALLOC, 16'd40000, 0, 1'b0, 16'd0,  1'b0},
    '{OP_ALLOC, 16'd20000, 0, 1'b0, 16'd0,  1'b0},  // payload above 32k
    '{OP_ALLOC, 16'd7,     0, 1'b0, 16'd0,  1'b0},
    '{OP_FREE,  16'h0000,  2, 1'b1, 16'd0,  1'b1},
    '{OP_ALLOC, 16'd32,    0, 1'b0, 16'd0,  1'b0}
  };

  initial begin
    ffha_out_t want;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_bus.valid  = 1'b0;
    in_bus.data   = '0;
    out_bus.ready = 1'b0;
    no_idle       = 1'b0;
    hold_left     = 0;
    hold_done     = 1'b0;
    quiet_cycles  = 0;
    err_count     = 0;
    top_brk       = BREAK_RESET;
    heap_reset();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part; typed rows overwrite the predicted entry
    foreach (directed[i]) begin
      if (directed[i].op == OP_FREE)
        free_at(directed[i].pick, directed[i].req);
      else
        send_word(OP_ALLOC, directed[i].req, 16'hFFFF);
      if (directed[i].typed) begin
        want.payload_address = directed[i].want_addr;
        want.ok              = directed[i].want_ok;
        pending_results[pending_results.size() - 1] = want;
      end
    end

    // random phases under different limits: reset value, smallest, above the heap, random, reset value again
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1: begin
          write_limit(LIMIT_W'(16));        // every extension fails
        end
        2: begin
          write_limit('1);                  // clamps to the heap size
        end
        3: begin
          write_limit(LIMIT_W'($urandom_range(LIMIT_RESET, 16)));
        end
        4: begin
          write_limit(LIMIT_W'(LIMIT_RESET));
        end
        default: ;
      endcase
      for (int k = 0; k < RANDOM_ITEMS / 5; k++) begin
        if (ph == 2) no_idle <= (k >= 50 && k < 250);
        random_word();
      end
      no_idle <= 1'b0;
      // after the first phase the sender pauses until all owed results are in
      if (ph == 0) drain();
    end

    drain();
    repeat (50) @(posedge clk);

    $display("run covered %0d allocations (%0d hit the limit) and %0d frees over %0d limit settings",
             n_alloc, n_alloc_fail, n_free, n_limits);
    $display("highest break reached %0d bytes, %0d result words checked, %0d errors",
             top_brk, n_results, err_count);
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ffha_pkg.sv
rtl/ffha_in_if.sv
rtl/ffha_out_if.sv
rtl/ffha_ram.sv
rtl/first_fit_heap_allocator.sv
rtl/ffha_checker.sv
tb/testbench.sv
